// ===== rtl/humidity_sensor_frame_decoder_top_defines.svh =====
// Assertion macros used by the checker of the frame decoder.
`ifndef HUMIDITY_SENSOR_FRAME_DECODER_TOP_DEFINES_SVH
`define HUMIDITY_SENSOR_FRAME_DECODER_TOP_DEFINES_SVH

// Check a property at every clock edge outside reset.
`define HSFD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("hsfd checker: property failed");

// Check a property at every clock edge, reset included.
`define HSFD_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("hsfd checker: property failed");

`endif

// ===== rtl/hsfd_pkg.sv =====
`timescale 1ns / 1ps

package hsfd_pkg;

   // byte positions within one reply
   localparam logic [2:0] POS_T_HI  = 3'd0;
   localparam logic [2:0] POS_T_LO  = 3'd1;
   localparam logic [2:0] POS_T_CRC = 3'd2;
   localparam logic [2:0] POS_H_HI  = 3'd3;
   localparam logic [2:0] POS_H_LO  = 3'd4;
   localparam logic [2:0] POS_H_CRC = 3'd5;

   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'h31;

   // status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_CRC   = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   // conversion constants
   localparam int TEMP_SCALE  = 17500;
   localparam int HUM_SCALE   = 12500;
   localparam int ROUND_BIAS  = 32767;
   localparam int TEMP_OFFSET = 4500;
   localparam int HUM_OFFSET  = 600;
   localparam int HUM_MAX     = 10000;
   localparam int TEMP_MIN    = -4000;
   localparam int TEMP_MAX    = 12500;

   localparam int TEMP_MIN_CENTI = TEMP_MIN;
   localparam int TEMP_MAX_CENTI = TEMP_MAX;

   typedef struct packed {
      logic [15:0] temp_word;
      logic [15:0] hum_word;
      logic        crc_good;
   } frame_type;

   function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

   // floor(x / 65535) for x below 32768 * 65535
   function automatic logic [14:0] div_65535(input logic [30:0] x);
      logic [14:0] q0;
      logic [16:0] r;
      q0 = x[30:16];
      r  = {1'b0, x[15:0]} + {2'b00, q0};
      return q0 + {14'd0, (r >= 17'd65535)};
   endfunction

endpackage

// ===== rtl/hsfd_if.sv =====
`timescale 1ns / 1ps

interface hsfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       frame_start;

   modport source (output valid, output rx_byte, output frame_start, input ready);
   modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface hsfd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [14:0] temperature_centi;
   logic        [13:0] humidity_centi;
   logic        [1:0]  status;

   modport source (output valid, output temperature_centi, output humidity_centi,
                   output status, input ready);
   modport sink   (input valid, input temperature_centi, input humidity_centi,
                   input status, output ready);
endinterface

// ===== rtl/hsfd_frame.sv =====
`timescale 1ns / 1ps

module hsfd_frame (
   input  logic                clock,
   input  logic                reset,
   hsfd_req_if.sink            req,
   output logic                frame_valid,
   input  logic                frame_ready,
   output hsfd_pkg::frame_type frame
);
   import hsfd_pkg::*;

   logic [2:0]  pos_ff, pos_in, pos_cur;
   logic [7:0]  crc_ff, crc_in;
   logic [15:0] temp_word_ff, temp_word_in;
   logic [15:0] hum_word_ff, hum_word_in;
   logic        temp_good_ff, temp_good_in;
   logic        valid_ff, valid_in;
   frame_type   frame_ff, frame_in;
   logic        accept;

   assign req.ready   = !valid_ff || frame_ready;
   assign accept      = req.valid && req.ready;
   assign frame_valid = valid_ff;
   assign frame       = frame_ff;

   always_comb begin
      pos_cur      = (req.frame_start || pos_ff > POS_H_CRC) ? POS_T_HI : pos_ff;
      pos_in       = pos_ff;
      crc_in       = crc_ff;
      temp_word_in = temp_word_ff;
      hum_word_in  = hum_word_ff;
      temp_good_in = temp_good_ff;
      valid_in     = valid_ff && !frame_ready;
      frame_in     = frame_ff;
      if (accept) begin
         pos_in = pos_cur + 3'd1;
         unique case (pos_cur)
            POS_T_HI: begin
               crc_in       = crc_feed(CRC_INIT, req.rx_byte);
               temp_word_in = {req.rx_byte, temp_word_ff[7:0]};
            end
            POS_T_LO: begin
               crc_in       = crc_feed(crc_ff, req.rx_byte);
               temp_word_in = {temp_word_ff[15:8], req.rx_byte};
            end
            POS_T_CRC: begin
               temp_good_in = (crc_ff == req.rx_byte);
               crc_in       = CRC_INIT;
            end
            POS_H_HI: begin
               crc_in      = crc_feed(CRC_INIT, req.rx_byte);
               hum_word_in = {req.rx_byte, hum_word_ff[7:0]};
            end
            POS_H_LO: begin
               crc_in      = crc_feed(crc_ff, req.rx_byte);
               hum_word_in = {hum_word_ff[15:8], req.rx_byte};
            end
            default: begin
               crc_in             = CRC_INIT;
               pos_in             = POS_T_HI;
               valid_in           = 1'b1;
               frame_in.temp_word = temp_word_ff;
               frame_in.hum_word  = hum_word_ff;
               frame_in.crc_good  = temp_good_ff && (crc_ff == req.rx_byte);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_T_HI;
         crc_ff       <= CRC_INIT;
         temp_word_ff <= '0;
         hum_word_ff  <= '0;
         temp_good_ff <= 1'b0;
         valid_ff     <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         temp_word_ff <= temp_word_in;
         hum_word_ff  <= hum_word_in;
         temp_good_ff <= temp_good_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
   end

endmodule

// ===== rtl/hsfd_scale.sv =====
`timescale 1ns / 1ps

module hsfd_scale (
   input  logic                clock,
   input  logic                reset,
   input  logic                frame_valid,
   output logic                frame_ready,
   input  hsfd_pkg::frame_type frame,
   hsfd_rsp_if.source          rsp
);
   import hsfd_pkg::*;

   logic               prod_valid_ff, prod_valid_in;
   logic [30:0]        temp_sum_ff, temp_sum_in;
   logic [29:0]        hum_sum_ff, hum_sum_in;
   logic               crc_good_ff, crc_good_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [14:0] temp_ff, temp_in;
   logic [13:0]        hum_ff, hum_in;
   logic [1:0]         status_ff, status_in;
   logic [14:0]        temp_q, hum_q;
   logic               out_ready, prod_ready;

   assign out_ready   = !rsp_valid_ff || rsp.ready;
   assign prod_ready  = !prod_valid_ff || out_ready;
   assign frame_ready = prod_ready;

   assign rsp.valid             = rsp_valid_ff;
   assign rsp.temperature_centi = temp_ff;
   assign rsp.humidity_centi    = hum_ff;
   assign rsp.status            = status_ff;

   // multiply and add the rounding bias
   always_comb begin
      prod_valid_in = prod_valid_ff && !out_ready;
      temp_sum_in   = temp_sum_ff;
      hum_sum_in    = hum_sum_ff;
      crc_good_in   = crc_good_ff;
      if (frame_valid && prod_ready) begin
         prod_valid_in = 1'b1;
         temp_sum_in   = {15'd0, frame.temp_word} * 31'(TEMP_SCALE) + 31'(ROUND_BIAS);
         hum_sum_in    = {14'd0, frame.hum_word} * 30'(HUM_SCALE) + 30'(ROUND_BIAS);
         crc_good_in   = frame.crc_good;
      end
   end

   // divide by 65535, offset, clamp the humidity and classify; zero both on a CRC error
   always_comb begin
      temp_q       = div_65535(temp_sum_ff);
      hum_q        = div_65535({1'b0, hum_sum_ff});
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      temp_in      = temp_ff;
      hum_in       = hum_ff;
      status_in    = status_ff;
      if (prod_valid_ff && out_ready) begin
         rsp_valid_in = 1'b1;
         if (!crc_good_ff) begin
            temp_in   = '0;
            hum_in    = '0;
            status_in = STATUS_CRC;
         end else begin
            temp_in = signed'(temp_q - 15'(TEMP_OFFSET));
            if (hum_q < 15'(HUM_OFFSET)) begin
               hum_in = '0;
            end else if (hum_q > 15'(HUM_OFFSET + HUM_MAX)) begin
               hum_in = 14'(HUM_MAX);
            end else begin
               hum_in = 14'(hum_q - 15'(HUM_OFFSET));
            end
            if (temp_q < 15'(TEMP_MIN + TEMP_OFFSET) ||
                temp_q > 15'(TEMP_MAX + TEMP_OFFSET)) begin
               status_in = STATUS_RANGE;
            end else begin
               status_in = STATUS_OK;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      temp_sum_ff <= temp_sum_in;
      hum_sum_ff  <= hum_sum_in;
      crc_good_ff <= crc_good_in;
      temp_ff     <= temp_in;
      hum_ff      <= hum_in;
      status_ff   <= status_in;
   end

endmodule

// ===== rtl/humidity_sensor_frame_decoder_top.sv =====
`timescale 1ns / 1ps
// Takes one reply byte per cycle; a byte is accepted in every cycle unless the result side stalls.
// After the sixth byte is accepted, the result passes the frame, multiply and divide registers
// in that order; one result per complete reply of six bytes.
// Reset (synchronous, active high) clears the byte count, the CRC and all valid flags;
// the first byte after reset starts a new reply.
module humidity_sensor_frame_decoder_top (
   input  logic       clock,
   input  logic       reset,
   hsfd_req_if.sink   req,
   hsfd_rsp_if.source rsp
);
   import hsfd_pkg::*;

   logic      frame_valid;
   logic      frame_ready;
   frame_type frame;

   hsfd_frame u_frame (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .frame_valid (frame_valid),
      .frame_ready (frame_ready),
      .frame       (frame)
   );

   hsfd_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .frame_valid (frame_valid),
      .frame_ready (frame_ready),
      .frame       (frame),
      .rsp         (rsp)
   );

endmodule

// ===== rtl/hsfd_checker.sv =====
`timescale 1ns / 1ps
`include "humidity_sensor_frame_decoder_top_defines.svh"

module hsfd_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [14:0] rsp_temperature_centi,
   input logic        [13:0] rsp_humidity_centi,
   input logic        [1:0]  rsp_status
);
   import hsfd_pkg::*;

   localparam logic signed [14:0] TEMP_LO = 15'(TEMP_MIN_CENTI);
   localparam logic signed [14:0] TEMP_HI = 15'(TEMP_MAX_CENTI);

   `HSFD_ASSERT_ALWAYS(a_idle_after_reset, clock, $past(reset) |-> !rsp_valid)
   `HSFD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_temperature_centi) && $stable(rsp_humidity_centi))
   `HSFD_ASSERT(a_crc_zero, clock, reset, rsp_valid && rsp_status == STATUS_CRC |-> rsp_temperature_centi == 15'sd0 && rsp_humidity_centi == 14'd0)
   `HSFD_ASSERT(a_hum_clamped, clock, reset, rsp_valid |-> rsp_humidity_centi <= 14'(HUM_MAX) && rsp_status <= STATUS_RANGE)
   `HSFD_ASSERT(a_ok_in_range, clock, reset, rsp_valid && rsp_status == STATUS_OK |-> rsp_temperature_centi >= TEMP_LO && rsp_temperature_centi <= TEMP_HI)

endmodule

bind humidity_sensor_frame_decoder_top hsfd_checker u_hsfd_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp.valid),
   .rsp_ready             (rsp.ready),
   .rsp_temperature_centi (rsp.temperature_centi),
   .rsp_humidity_centi    (rsp.humidity_centi),
   .rsp_status            (rsp.status)
);

// ===== verif/tb_humidity_sensor_frame_decoder_top.sv =====
`timescale 1ns / 1ps

module tb_humidity_sensor_frame_decoder_top;
   import hsfd_pkg::*;

   localparam int FULL_SCALE     = 65535;
   localparam int QUIET_TAIL     = 120;
   localparam int RANDOM_BYTES   = 780;
   localparam int LONG_HOLD      = 250;
   localparam int HOLD_AT        = 30;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_start;
      logic       wait_idle;
   } reply_byte_type;

   typedef struct packed {
      logic signed [14:0] temperature_centi;
      logic        [13:0] humidity_centi;
      logic        [1:0]  status;
   } reading_type;

   logic clock;
   logic reset;

   hsfd_req_if req_bus ();
   hsfd_rsp_if rsp_bus ();

   humidity_sensor_frame_decoder_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   reply_byte_type reply_bytes[$];
   reading_type    pending_readings[$];
   reply_byte_type on_bus;

   logic [2:0]  dec_pos;
   logic [7:0]  dec_crc;
   logic [15:0] dec_temp;
   logic [15:0] dec_hum;
   logic        dec_temp_ok;

   int unsigned gap_left;
   int unsigned ready_gap;
   int unsigned long_hold;
   bit          long_hold_done;
   int unsigned readings_seen;
   int unsigned mismatches;
   int unsigned idle_cycles;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc;
      for (int k = 7; k >= 0; k--) begin
         c = (c[7] ^ b[k]) ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   task automatic decode_byte(input logic [7:0] b, input logic start);
      logic [2:0]  pos;
      logic        hum_ok;
      longint      qt;
      longint      qh;
      int          t;
      int          h;
      reading_type r;
      pos = dec_pos;
      if (start || dec_pos > POS_H_CRC) begin
         pos     = POS_T_HI;
         dec_crc = CRC_INIT;
      end
      case (pos)
         POS_T_HI: begin
            dec_crc        = crc8_step(CRC_INIT, b);
            dec_temp[15:8] = b;
         end
         POS_T_LO: begin
            dec_crc       = crc8_step(dec_crc, b);
            dec_temp[7:0] = b;
         end
         POS_T_CRC: begin
            dec_temp_ok = (dec_crc == b);
            dec_crc     = CRC_INIT;
         end
         POS_H_HI: begin
            dec_crc       = crc8_step(CRC_INIT, b);
            dec_hum[15:8] = b;
         end
         POS_H_LO: begin
            dec_crc      = crc8_step(dec_crc, b);
            dec_hum[7:0] = b;
         end
         default: begin
            hum_ok  = (dec_crc == b);
            dec_crc = CRC_INIT;
            if (!(dec_temp_ok && hum_ok)) begin
               r.temperature_centi = '0;
               r.humidity_centi    = '0;
               r.status            = STATUS_CRC;
            end else begin
               qt = (longint'(TEMP_SCALE) * longint'(dec_temp) + ROUND_BIAS) / FULL_SCALE;
               qh = (longint'(HUM_SCALE) * longint'(dec_hum) + ROUND_BIAS) / FULL_SCALE;
               t  = int'(qt) - TEMP_OFFSET;
               h  = int'(qh) - HUM_OFFSET;
               if (h < 0) h = 0;
               if (h > HUM_MAX) h = HUM_MAX;
               r.temperature_centi = t[14:0];
               r.humidity_centi    = h[13:0];
               r.status = (t >= TEMP_MIN && t <= TEMP_MAX) ? STATUS_OK : STATUS_RANGE;
            end
            pending_readings.push_back(r);
         end
      endcase
      dec_pos = (pos >= POS_H_CRC) ? POS_T_HI : pos + 3'd1;
   endtask

   task automatic add_reply(input logic [15:0] t_raw, input logic [15:0] h_raw,
                            input logic start, input bit t_bad, input bit h_bad,
                            input bit hold, input int unsigned keep);
      logic [7:0]     b[6];
      reply_byte_type it;
      b[0] = t_raw[15:8];
      b[1] = t_raw[7:0];
      b[2] = crc8_step(crc8_step(CRC_INIT, b[0]), b[1]);
      b[3] = h_raw[15:8];
      b[4] = h_raw[7:0];
      b[5] = crc8_step(crc8_step(CRC_INIT, b[3]), b[4]);
      if (t_bad) b[2] ^= 8'($urandom_range(1, 255));
      if (h_bad) b[5] ^= 8'($urandom_range(1, 255));
      for (int k = 0; k < keep && k < 6; k++) begin
         it.rx_byte     = b[k];
         it.frame_start = (k == 0) ? start : 1'b0;
         it.wait_idle   = (k == 0) ? hold : 1'b0;
         reply_bytes.push_back(it);
      end
   endtask

   function automatic logic [15:0] pick_temp_raw();
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         1: return 16'($urandom_range(1860, 1885));
         2: return 16'($urandom_range(63650, 63675));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_hum_raw();
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         1: return 16'($urandom_range(0, 3300));
         2: return 16'($urandom_range(57000, 65535));
         default: return 16'($urandom);
      endcase
   endfunction

   always @(posedge clock) begin : drive_requests
      reply_byte_type nxt;
      if (reset) begin
         req_bus.valid       <= 1'b0;
         req_bus.rx_byte     <= '0;
         req_bus.frame_start <= 1'b0;
         gap_left    = 0;
         dec_pos     = POS_T_HI;
         dec_crc     = CRC_INIT;
         dec_temp    = '0;
         dec_hum     = '0;
         dec_temp_ok = 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            decode_byte(on_bus.rx_byte, on_bus.frame_start);
            if (reply_bytes.size() >= QUIET_TAIL && $urandom_range(0, 4) == 0) begin
               gap_left = $urandom_range(1, 7);
            end
         end
         if (!(req_bus.valid && !req_bus.ready)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (reply_bytes.size() > 0 &&
                         !(reply_bytes[0].wait_idle && pending_readings.size() != 0)) begin
               nxt    = reply_bytes.pop_front();
               on_bus = nxt;
               req_bus.valid       <= 1'b1;
               req_bus.rx_byte     <= nxt.rx_byte;
               req_bus.frame_start <= nxt.frame_start;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_readings
      reading_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         ready_gap      = 0;
         long_hold      = 0;
         long_hold_done = 1'b0;
         readings_seen  = 0;
         mismatches     = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            readings_seen++;
            if (pending_readings.size() == 0) begin
               $error("reading with none pending: temperature_centi %0d humidity_centi %0d status %0d",
                      $signed(rsp_bus.temperature_centi), rsp_bus.humidity_centi, rsp_bus.status);
               mismatches++;
            end else begin
               want = pending_readings.pop_front();
               if (rsp_bus.temperature_centi !== want.temperature_centi) begin
                  $error("temperature_centi: expected %0d, actual %0d",
                         $signed(want.temperature_centi), $signed(rsp_bus.temperature_centi));
                  mismatches++;
               end
               if (rsp_bus.humidity_centi !== want.humidity_centi) begin
                  $error("humidity_centi: expected %0d, actual %0d",
                         want.humidity_centi, rsp_bus.humidity_centi);
                  mismatches++;
               end
               if (rsp_bus.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_bus.status);
                  mismatches++;
               end
            end
         end
         if (long_hold > 0) begin
            long_hold--;
            rsp_bus.ready <= 1'b0;
         end else if (!long_hold_done && readings_seen >= HOLD_AT) begin
            long_hold_done = 1'b1;
            long_hold      = LONG_HOLD - 1;
            rsp_bus.ready <= 1'b0;
         end else if (ready_gap > 0) begin
            ready_gap--;
            rsp_bus.ready <= 1'b0;
         end else if (reply_bytes.size() >= QUIET_TAIL && $urandom_range(0, 5) == 0) begin
            ready_gap = $urandom_range(1, 7) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_humidity_sensor_frame_decoder_top failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int unsigned    choice;
      int unsigned    n_replies;
      bit             resync;
      reply_byte_type it;
      reset = 1'b1;

      add_reply(16'h0000, 16'h0000, 1'b1, 0, 0, 0, 6);
      add_reply(16'hFFFF, 16'hFFFF, 1'b0, 0, 0, 0, 6);
      add_reply(16'h6666, 16'h8000, 1'b1, 0, 1, 0, 6);
      add_reply(16'h5A5A, 16'hA5A5, 1'b1, 0, 0, 0, 3);
      add_reply(16'h0000, 16'h1234, 1'b1, 1, 0, 0, 6);

      n_replies = 0;
      resync    = 1'b1;
      while (reply_bytes.size() < RANDOM_BYTES) begin
         choice = $urandom_range(0, 99);
         if (choice < 80) begin
            add_reply(pick_temp_raw(), pick_hum_raw(), resync || $urandom_range(0, 1),
                      $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0,
                      n_replies % 40 == 20, 6);
            n_replies++;
            resync = 1'b0;
         end else if (choice < 90) begin
            add_reply(pick_temp_raw(), pick_hum_raw(), $urandom_range(0, 1), 0, 0, 0,
                      $urandom_range(1, 5));
            resync = 1'b1;
         end else begin
            repeat ($urandom_range(1, 8)) begin
               it.rx_byte     = 8'($urandom);
               it.frame_start = $urandom_range(0, 1);
               it.wait_idle   = 1'b0;
               reply_bytes.push_back(it);
            end
            resync = 1'b1;
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (reply_bytes.size() != 0 || req_bus.valid) @(posedge clock);
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatches == 0) begin
         $display("tb_humidity_sensor_frame_decoder_top passed");
      end else begin
         $display("tb_humidity_sensor_frame_decoder_top failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/hsfd_pkg.sv
rtl/hsfd_if.sv
rtl/hsfd_frame.sv
rtl/hsfd_scale.sv
rtl/humidity_sensor_frame_decoder_top.sv
rtl/hsfd_checker.sv
verif/tb_humidity_sensor_frame_decoder_top.sv
